// ===== design/bia_pkg.sv =====
// Shared types, constants and helpers for the bump item allocator.
package bia_pkg;

	localparam int MAX_ITEMS = 1024;
	localparam int MAX_BATCH = 16;
	localparam int ID_W      = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int BATCH_W   = 5;
	localparam int OP_W      = 2;
	localparam int STATUS_W  = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [CNT_W-1:0]   CAP_MAX   = CNT_W'(MAX_ITEMS);
	localparam logic [BATCH_W-1:0] BATCH_MAX = BATCH_W'(MAX_BATCH);

	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE = 3'd1;
	localparam logic [STATUS_W-1:0] ST_RESERVED = 3'd2;
	localparam logic [STATUS_W-1:0] ST_DOUBLE   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESERVED = 2'd1;

	typedef struct packed {
		logic [CNT_W-1:0] eff_cap;
		logic [CNT_W-1:0] eff_res;
		logic [CNT_W-1:0] span;
	} cfg_eff_t;

	function automatic logic [CNT_W-1:0] sub_floor(input logic [CNT_W-1:0] a,
		input logic [CNT_W-1:0] b);
		return (a > b) ? (a - b) : '0;
	endfunction

endpackage

// ===== design/bia_mark_ram.sv =====
// Allocated-mark memory, one bit per item, one write and one registered read port.
module bia_mark_ram (
	input  logic                    clk,
	input  logic                    we,
	input  logic [bia_pkg::ID_W-1:0] waddr,
	input  logic                    wdata,
	input  logic                    re,
	input  logic [bia_pkg::ID_W-1:0] raddr,
	output logic                    rdata
);
	import bia_pkg::*;

	logic mem [MAX_ITEMS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/bia_cfg.sv =====
// Configuration registers and the clamped capacity and reserved counts.
module bia_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [bia_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [bia_pkg::CNT_W-1:0]     wr_data,
	output bia_pkg::cfg_eff_t             eff
);
	import bia_pkg::*;

	logic [CNT_W-1:0] capacity_q;
	logic [CNT_W-1:0] reserved_q;
	logic [CNT_W-1:0] cap_c;
	logic [CNT_W-1:0] res_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_MAX;
			reserved_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				REG_CAPACITY: capacity_q <= wr_data;
				REG_RESERVED: reserved_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		cap_c       = (capacity_q > CAP_MAX) ? CAP_MAX : capacity_q;
		res_c       = (reserved_q > cap_c) ? cap_c : reserved_q;
		eff.eff_cap = cap_c;
		eff.eff_res = res_c;
		eff.span    = cap_c - res_c;
	end

endmodule

// ===== design/bump_item_allocator_core.sv =====
// Top level: request sequencer, counters and result register of the bump item allocator.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------------
//  req     | req_valid / req_stall | operation, count, item_index
//  rsp     | rsp_valid / rsp_stall | status, item_id, last, free_total, free_at_end,
//          |                       | is_empty
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Clear and unknown requests answer from idle; a free waits for the mark memory read.
// A valid allocation of n items gives n beats, one per cycle while rsp is not stalled.
// After reset a sweep clears the whole mark memory; req_stall stays high meanwhile.
// A stalled rsp beat holds the result register and halts the sequencer.
module bump_item_allocator_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [bia_pkg::OP_W-1:0]       operation,
	input  logic [bia_pkg::BATCH_W-1:0]    count,
	input  logic [bia_pkg::ID_W-1:0]       item_index,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [bia_pkg::STATUS_W-1:0]   status,
	output logic [bia_pkg::ID_W-1:0]       item_id,
	output logic                          last,
	output logic [bia_pkg::CNT_W-1:0]      free_total,
	output logic [bia_pkg::CNT_W-1:0]      free_at_end,
	output logic                          is_empty,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bia_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bia_pkg::CNT_W-1:0]      cfg_data
);
	import bia_pkg::*;

	localparam logic [1:0] S_INIT  = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_ALLOC = 2'd2;
	localparam logic [1:0] S_FREE  = 2'd3;

	cfg_eff_t eff;

	logic [1:0]          state_q, state_d;
	logic [ID_W-1:0]     sweep_q;
	logic [CNT_W-1:0]    bump_q, bump_d;
	logic [CNT_W-1:0]    live_q, live_d;
	logic [ID_W-1:0]     next_id_q, next_id_d;
	logic [BATCH_W-1:0]  remain_q, remain_d;
	logic [ID_W-1:0]     free_idx_s1;

	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [ID_W-1:0]     item_id_q;
	logic                last_q;
	logic [CNT_W-1:0]    free_total_q;
	logic [CNT_W-1:0]    free_at_end_q;
	logic                is_empty_q;

	logic                slot_free;
	logic                accept;
	logic                emit;
	logic [STATUS_W-1:0] emit_status;
	logic [ID_W-1:0]     emit_id;
	logic                emit_last;
	logic [CNT_W-1:0]    avail_end_c;
	logic [CNT_W-1:0]    base_c;
	logic                bad_alloc;
	logic                mark_we;
	logic [ID_W-1:0]     mark_waddr;
	logic                mark_wdata;
	logic                mark_re;
	logic                mark_rdata;

	bia_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.eff      (eff)
	);

	bia_mark_ram u_mark (
		.clk   (clk),
		.we    (mark_we),
		.waddr (mark_waddr),
		.wdata (mark_wdata),
		.re    (mark_re),
		.raddr (item_index),
		.rdata (mark_rdata)
	);

	assign cfg_ready = 1'b1;
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = !((state_q == S_IDLE) && slot_free);
	assign accept    = req_valid && !req_stall;
	assign mark_re   = accept && (operation == OP_FREE);

	assign avail_end_c = sub_floor(eff.span, bump_q);
	assign base_c      = eff.eff_res + bump_q;
	assign bad_alloc   = (count == '0) || (count > BATCH_MAX)
		|| ({{(CNT_W-BATCH_W){1'b0}}, count} > avail_end_c);

	always_comb begin
		state_d     = state_q;
		bump_d      = bump_q;
		live_d      = live_q;
		next_id_d   = next_id_q;
		remain_d    = remain_q;
		emit        = 1'b0;
		emit_status = ST_OK;
		emit_id     = '0;
		emit_last   = 1'b1;
		mark_we     = 1'b0;
		mark_waddr  = sweep_q;
		mark_wdata  = 1'b0;
		case (state_q)
			S_INIT: begin
				mark_we = 1'b1;
				if (sweep_q == ID_W'(MAX_ITEMS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					case (operation)
						OP_ALLOC: begin
							emit = 1'b1;
							if (bad_alloc) begin
								emit_status = ST_NO_SPACE;
							end else begin
								emit_id    = base_c[ID_W-1:0];
								emit_last  = (count == BATCH_W'(1));
								mark_we    = 1'b1;
								mark_waddr = base_c[ID_W-1:0];
								mark_wdata = 1'b1;
								bump_d     = bump_q + {{(CNT_W-BATCH_W){1'b0}}, count};
								live_d     = live_q + {{(CNT_W-BATCH_W){1'b0}}, count};
								next_id_d  = base_c[ID_W-1:0] + ID_W'(1);
								remain_d   = count - BATCH_W'(1);
								if (count != BATCH_W'(1)) begin
									state_d = S_ALLOC;
								end
							end
						end
						OP_FREE: begin
							state_d = S_FREE;
						end
						OP_CLEAR: begin
							emit   = 1'b1;
							bump_d = '0;
							live_d = '0;
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			S_ALLOC: begin
				if (slot_free) begin
					emit       = 1'b1;
					emit_id    = next_id_q;
					emit_last  = (remain_q == BATCH_W'(1));
					mark_we    = 1'b1;
					mark_waddr = next_id_q;
					mark_wdata = 1'b1;
					next_id_d  = next_id_q + ID_W'(1);
					remain_d   = remain_q - BATCH_W'(1);
					if (remain_q == BATCH_W'(1)) begin
						state_d = S_IDLE;
					end
				end
			end
			S_FREE: begin
				if (slot_free) begin
					emit    = 1'b1;
					state_d = S_IDLE;
					if ({1'b0, free_idx_s1} >= eff.eff_cap) begin
						emit_status = ST_RANGE;
					end else if (mark_rdata) begin
						mark_we    = 1'b1;
						mark_waddr = free_idx_s1;
						mark_wdata = 1'b0;
						if (live_q != '0) begin
							live_d = live_q - CNT_W'(1);
						end
					end else if ({1'b0, free_idx_s1} < eff.eff_res) begin
						emit_status = ST_RESERVED;
					end else begin
						emit_status = ST_DOUBLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			sweep_q     <= '0;
			bump_q      <= '0;
			live_q      <= '0;
			remain_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			bump_q   <= bump_d;
			live_q   <= live_d;
			remain_q <= remain_d;
			if (state_q == S_INIT) begin
				sweep_q <= sweep_q + ID_W'(1);
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		next_id_q <= next_id_d;
		if (mark_re) begin
			free_idx_s1 <= item_index;
		end
		if (emit) begin
			status_q      <= emit_status;
			item_id_q     <= emit_id;
			last_q        <= emit_last;
			free_total_q  <= sub_floor(eff.span, live_d);
			free_at_end_q <= sub_floor(eff.span, bump_d);
			is_empty_q    <= (live_d == '0);
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign item_id     = item_id_q;
	assign last        = last_q;
	assign free_total  = free_total_q;
	assign free_at_end = free_at_end_q;
	assign is_empty    = is_empty_q;

`ifndef SYNTH
	a_live_le_bump: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= bump_q)
		else $error("live count exceeds bump offset");

	a_bump_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bump_q <= CAP_MAX)
		else $error("bump offset past store size");

	a_free_reads: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (operation == OP_FREE) |=> (state_q == S_FREE) && !rsp_valid_q)
		else $error("free request did not wait for mark read");

	a_alloc_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (state_q == S_ALLOC) |-> !last_q)
		else $error("last beat shown while batch still running");
`endif

endmodule

// ===== bench/bia_monitor.sv =====
// Checker for the bump item allocator: predicts every response beat and compares it.
module bia_monitor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic                          req_stall,
	input  logic [bia_pkg::OP_W-1:0]      operation,
	input  logic [bia_pkg::BATCH_W-1:0]   count,
	input  logic [bia_pkg::ID_W-1:0]      item_index,
	input  logic                          rsp_valid,
	input  logic                          rsp_stall,
	input  logic [bia_pkg::STATUS_W-1:0]  status,
	input  logic [bia_pkg::ID_W-1:0]      item_id,
	input  logic                          last,
	input  logic [bia_pkg::CNT_W-1:0]     free_total,
	input  logic [bia_pkg::CNT_W-1:0]     free_at_end,
	input  logic                          is_empty,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [bia_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bia_pkg::CNT_W-1:0]     cfg_data,
	output int                            fail_count,
	output int                            pending
);
	import bia_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ID_W-1:0]     item_id;
		logic                last;
		logic [CNT_W-1:0]    free_total;
		logic [CNT_W-1:0]    free_at_end;
		logic                is_empty;
	} beat_t;

	beat_t due_beats[$];

	bit               marks [MAX_ITEMS];
	logic [CNT_W-1:0] cap_reg  = CAP_MAX;
	logic [CNT_W-1:0] res_reg  = '0;
	logic [CNT_W-1:0] bump_off = '0;
	logic [CNT_W-1:0] live     = '0;

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic logic [CNT_W-1:0] cap_eff();
		return (cap_reg > CAP_MAX) ? CAP_MAX : cap_reg;
	endfunction

	function automatic logic [CNT_W-1:0] res_eff();
		logic [CNT_W-1:0] c;
		c = cap_eff();
		return (res_reg > c) ? c : res_reg;
	endfunction

	function automatic logic [CNT_W-1:0] headroom(input logic [CNT_W-1:0] used);
		logic [CNT_W-1:0] span;
		span = cap_eff() - res_eff();
		return (span > used) ? span - used : '0;
	endfunction

	function automatic beat_t make_beat(input logic [STATUS_W-1:0] st,
		input logic [ID_W-1:0] id, input logic lst);
		beat_t b;
		b.status = st;
		b.item_id = id;
		b.last = lst;
		b.free_total = headroom(live);
		b.free_at_end = headroom(bump_off);
		b.is_empty = (live == '0);
		return b;
	endfunction

	task automatic apply_request(input logic [OP_W-1:0] op, input logic [BATCH_W-1:0] cnt,
		input logic [ID_W-1:0] idx);
		logic [CNT_W-1:0]    base;
		logic [STATUS_W-1:0] st;
		int                  k;
		case (op)
			OP_ALLOC: begin
				if (cnt == '0 || cnt > BATCH_MAX || CNT_W'(cnt) > headroom(bump_off)) begin
					due_beats.push_back(make_beat(ST_NO_SPACE, '0, 1'b1));
				end else begin
					base = res_eff() + bump_off;
					for (k = 0; k < int'(cnt); k++)
						marks[ID_W'(int'(base) + k)] = 1'b1;
					bump_off = bump_off + CNT_W'(cnt);
					live = live + CNT_W'(cnt);
					for (k = 0; k < int'(cnt); k++)
						due_beats.push_back(make_beat(ST_OK, ID_W'(int'(base) + k),
							k == int'(cnt) - 1));
				end
			end
			OP_FREE: begin
				if (CNT_W'(idx) >= cap_eff()) begin
					st = ST_RANGE;
				end else if (marks[idx]) begin
					marks[idx] = 1'b0;
					if (live != '0)
						live = live - CNT_W'(1);
					st = ST_OK;
				end else if (CNT_W'(idx) < res_eff()) begin
					st = ST_RESERVED;
				end else begin
					st = ST_DOUBLE;
				end
				due_beats.push_back(make_beat(st, '0, 1'b1));
			end
			OP_CLEAR: begin
				bump_off = '0;
				live = '0;
				due_beats.push_back(make_beat(ST_OK, '0, 1'b1));
			end
			default: begin
				due_beats.push_back(make_beat(ST_OK, '0, 1'b1));
			end
		endcase
	endtask

	always @(posedge clk) begin
		beat_t got, want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_CAPACITY)
					cap_reg = cfg_data;
				else if (cfg_index == REG_RESERVED)
					res_reg = cfg_data;
			end
			if (rsp_valid && !rsp_stall) begin
				got = '{status, item_id, last, free_total, free_at_end, is_empty};
				if (due_beats.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected beat status %0d id %0d last %0d",
							$realtime, status, item_id, last);
				end else begin
					want = due_beats.pop_front();
					if (got.status != want.status || got.item_id != want.item_id ||
						got.last != want.last || got.free_total != want.free_total ||
						got.free_at_end != want.free_at_end || got.is_empty != want.is_empty) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"%0t: beat mismatch, expected status %0d id %0d last %0d ",
								"free_total %0d free_at_end %0d empty %0d, got status %0d id %0d ",
								"last %0d free_total %0d free_at_end %0d empty %0d"}, $realtime,
								want.status, want.item_id, want.last, want.free_total,
								want.free_at_end, want.is_empty, got.status, got.item_id,
								got.last, got.free_total, got.free_at_end, got.is_empty);
					end
				end
			end
			if (req_valid && !req_stall)
				apply_request(operation, count, item_index);
			pending = due_beats.size();
		end
	end

endmodule

// ===== bench/testbench.sv =====
// Top of the bump item allocator bench: clock, reset, stimulus, stall pattern and verdict.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [bia_pkg::OP_W-1:0] OP_NOP = 2'd3;
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 200;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            req_valid = 1'b0;
	logic                            req_stall;
	logic [bia_pkg::OP_W-1:0]        operation = '0;
	logic [bia_pkg::BATCH_W-1:0]     count = '0;
	logic [bia_pkg::ID_W-1:0]        item_index = '0;
	logic                            rsp_valid;
	logic                            rsp_stall = 1'b0;
	logic [bia_pkg::STATUS_W-1:0]    status;
	logic [bia_pkg::ID_W-1:0]        item_id;
	logic                            last;
	logic [bia_pkg::CNT_W-1:0]       free_total;
	logic [bia_pkg::CNT_W-1:0]       free_at_end;
	logic                            is_empty;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [bia_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
	logic [bia_pkg::CNT_W-1:0]       cfg_data = '0;

	int fail_count;
	int pending;
	int req_idle_pct = 32;
	int rsp_idle_pct = 51;
	int cap_now = 1024;
	int hold_left = 0;
	int quiet = 0;
	bit hold_start = 1'b0;
	bit hold_done = 1'b0;

	bump_item_allocator_core dut (.*);

	bia_monitor monitor (.*);

	initial forever #5 clk = ~clk;

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else if (hold_start && !hold_done) begin
			hold_left <= HOLD_CYCLES - 1;
			hold_done <= 1'b1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic send_req(input logic [bia_pkg::OP_W-1:0] op,
		input logic [bia_pkg::BATCH_W-1:0] cnt, input logic [bia_pkg::ID_W-1:0] idx);
		while ($urandom_range(99) < req_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		operation <= op;
		count <= cnt;
		item_index <= idx;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	task automatic settle();
		req_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_put(input logic [bia_pkg::CFG_IDX_W-1:0] idx,
		input logic [bia_pkg::CNT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic set_regs(input logic [bia_pkg::CNT_W-1:0] cap,
		input logic [bia_pkg::CNT_W-1:0] res);
		cfg_put(bia_pkg::REG_CAPACITY, cap);
		cfg_put(bia_pkg::REG_RESERVED, res);
		cfg_valid <= 1'b0;
		cap_now = (cap > bia_pkg::CAP_MAX) ? bia_pkg::MAX_ITEMS : int'(cap);
	endtask

	initial begin
		int                          phase;
		int                          seg;
		int                          n;
		int                          pick;
		logic [bia_pkg::OP_W-1:0]    op_v;
		logic [bia_pkg::BATCH_W-1:0] cnt_v;
		logic [bia_pkg::ID_W-1:0]    idx_v;
		logic [bia_pkg::CNT_W-1:0]   cap_v;
		logic [bia_pkg::CNT_W-1:0]   res_v;

		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		send_req(bia_pkg::OP_ALLOC, 5'd0, 10'd0);
		send_req(bia_pkg::OP_ALLOC, 5'd17, 10'd0);
		send_req(bia_pkg::OP_ALLOC, 5'd31, 10'd1023);
		send_req(bia_pkg::OP_ALLOC, 5'd1, 10'd0);
		send_req(bia_pkg::OP_ALLOC, 5'd16, 10'd0);
		send_req(bia_pkg::OP_FREE, 5'd0, 10'd0);
		send_req(bia_pkg::OP_FREE, 5'd31, 10'd0);
		send_req(bia_pkg::OP_FREE, 5'd1, 10'd1023);
		send_req(OP_NOP, 5'd31, 10'd1023);
		send_req(bia_pkg::OP_CLEAR, 5'd0, 10'd0);
		send_req(bia_pkg::OP_FREE, 5'd1, 10'd5);
		send_req(bia_pkg::OP_ALLOC, 5'd16, 10'd0);
		settle();
		set_regs(11'd20, 11'd4);
		send_req(bia_pkg::OP_FREE, 5'd1, 10'd2);
		send_req(bia_pkg::OP_FREE, 5'd1, 10'd2);
		send_req(bia_pkg::OP_FREE, 5'd1, 10'd20);
		send_req(bia_pkg::OP_FREE, 5'd1, 10'd1023);
		send_req(bia_pkg::OP_ALLOC, 5'd16, 10'd0);
		send_req(bia_pkg::OP_CLEAR, 5'd0, 10'd0);
		send_req(bia_pkg::OP_ALLOC, 5'd16, 10'd0);
		send_req(bia_pkg::OP_ALLOC, 5'd1, 10'd0);
		settle();
		set_regs(11'd2047, 11'd2047);
		send_req(bia_pkg::OP_ALLOC, 5'd1, 10'd0);
		send_req(bia_pkg::OP_FREE, 5'd1, 10'd1023);
		settle();
		set_regs(11'd0, 11'd0);
		send_req(bia_pkg::OP_FREE, 5'd1, 10'd0);
		send_req(bia_pkg::OP_ALLOC, 5'd1, 10'd0);

		for (phase = 0; phase < 3; phase++) begin
			req_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 51 : 0;
			rsp_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 32 : 0;
			for (seg = 0; seg < 3; seg++) begin
				settle();
				pick = $urandom_range(5);
				if (pick == 0)
					cap_v = bia_pkg::CAP_MAX;
				else if (pick == 1)
					cap_v = bia_pkg::CNT_W'($urandom_range(1025, 2047));
				else
					cap_v = bia_pkg::CNT_W'($urandom_range(1, 48));
				res_v = ($urandom_range(7) == 0) ? bia_pkg::CNT_W'($urandom_range(2047)) :
					bia_pkg::CNT_W'($urandom_range(8));
				set_regs(cap_v, res_v);
				if (phase == 2 && seg == 1)
					hold_start = 1'b1;
				for (n = 0; n < 26; n++) begin
					pick = $urandom_range(99);
					op_v = (pick < 48) ? bia_pkg::OP_ALLOC : (pick < 82) ? bia_pkg::OP_FREE :
						(pick < 94) ? bia_pkg::OP_CLEAR : OP_NOP;
					cnt_v = ($urandom_range(9) == 0) ? bia_pkg::BATCH_W'($urandom_range(31)) :
						bia_pkg::BATCH_W'($urandom_range(1, bia_pkg::MAX_BATCH));
					if (cap_now < 1023 && $urandom_range(3) != 0)
						idx_v = bia_pkg::ID_W'($urandom_range(cap_now + 1));
					else
						idx_v = bia_pkg::ID_W'($urandom_range(1023));
					send_req(op_v, cnt_v, idx_v);
				end
			end
		end

		settle();
		repeat (16) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
